// ===== hw/rtl/hrs_pkg.sv =====
`timescale 1ns / 1ps

package hrs_pkg;

  // Stream length limit; the sample at MAX_SAMPLES-1 always ends the stream.
  localparam int unsigned MAX_SAMPLES = 65536;
  localparam int unsigned POS_W       = $clog2(MAX_SAMPLES);

  localparam int unsigned AMP_W   = 8;
  localparam int unsigned RATE_W  = 3;
  localparam int unsigned START_W = 16;
  localparam int unsigned END_W   = 17;

  // Zeros a head absorbs before it is closed with the slowest rate.
  localparam logic [RATE_W-1:0] ABSORB_LIMIT = RATE_W'(4);

  // Result queue: room for two words from one accepted sample on top of two already held.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [AMP_W-1:0]   amplitude;
    logic [RATE_W-1:0]  rate_code;
    logic [START_W-1:0] start_index;
    logic [END_W-1:0]   end_index;
    logic               last_segment;
  } seg_t;

endpackage

// ===== hw/rtl/hrs_in_if.sv =====
`timescale 1ns / 1ps

interface hrs_in_if;
  logic                         valid;
  logic                         ready;
  logic [hrs_pkg::AMP_W-1:0]    sample;
  logic                         final_sample;

  modport source (output valid, output sample, output final_sample, input ready);
  modport sink   (input valid, input sample, input final_sample, output ready);
endinterface

// ===== hw/rtl/hrs_out_if.sv =====
`timescale 1ns / 1ps

interface hrs_out_if;
  logic                          valid;
  logic                          ready;
  logic [hrs_pkg::AMP_W-1:0]     amplitude;
  logic [hrs_pkg::RATE_W-1:0]    rate_code;
  logic [hrs_pkg::START_W-1:0]   start_index;
  logic [hrs_pkg::END_W-1:0]     end_index;
  logic                          last_segment;

  modport source (output valid, output amplitude, output rate_code, output start_index,
                  output end_index, output last_segment, input ready);
  modport sink   (input valid, input amplitude, input rate_code, input start_index,
                  input end_index, input last_segment, output ready);
endinterface

// ===== hw/rtl/haptic_rate_segmenter_top.sv =====
`timescale 1ns / 1ps
// A segment word is registered into the queue when the sample closing it is accepted.
// Throughput: one sample per cycle while in_smp.ready is high; a nonzero final sample
//   closing an open head yields two words; the 4-word queue drains one word per cycle
//   while out_seg.ready is high. in_smp.ready is high while the queue holds at most two.
// Reset (rst_n low, synchronous): no open head, position zero, result queue empty.

module haptic_rate_segmenter_top (
  input  logic     clk,
  input  logic     rst_n,
  hrs_in_if.sink   in_smp,
  hrs_out_if.source out_seg
);

  // Segment state
  logic                           head_open_r;
  logic [hrs_pkg::AMP_W-1:0]      head_amp_r;
  logic [hrs_pkg::POS_W-1:0]      head_start_r;
  logic [hrs_pkg::RATE_W-1:0]     zero_run_r;
  logic [hrs_pkg::POS_W-1:0]      pos_r;

  logic                           head_open_nxt;
  logic [hrs_pkg::AMP_W-1:0]      head_amp_nxt;
  logic [hrs_pkg::POS_W-1:0]      head_start_nxt;
  logic [hrs_pkg::RATE_W-1:0]     zero_run_nxt;
  logic [hrs_pkg::POS_W-1:0]      pos_nxt;

  // Result queue
  hrs_pkg::seg_t                  q_r [hrs_pkg::QDEPTH];
  logic [hrs_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [hrs_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [hrs_pkg::QCNT_W-1:0]     cnt_r;

  logic                           in_acc;
  logic                           out_acc;
  logic                           fin;
  logic                           is_zero;
  logic [hrs_pkg::RATE_W-1:0]     zr_inc;
  logic [hrs_pkg::END_W-1:0]      pos_end;
  hrs_pkg::seg_t                  res0;
  hrs_pkg::seg_t                  res1;
  logic [1:0]                     n_push;

  assign in_smp.ready = (cnt_r <= hrs_pkg::QCNT_W'(hrs_pkg::QDEPTH - 2));
  assign in_acc       = in_smp.valid && in_smp.ready;
  assign out_seg.valid = (cnt_r != '0);
  assign out_acc      = out_seg.valid && out_seg.ready;

  // Stream is cut at the last addressable position so positions never wrap.
  assign fin     = in_smp.final_sample ||
                   (pos_r == hrs_pkg::POS_W'(hrs_pkg::MAX_SAMPLES - 1));
  assign is_zero = (in_smp.sample == '0);
  assign zr_inc  = zero_run_r + hrs_pkg::RATE_W'(1);
  assign pos_end = hrs_pkg::END_W'(pos_r) + hrs_pkg::END_W'(1);

  always_comb begin
    head_open_nxt  = head_open_r;
    head_amp_nxt   = head_amp_r;
    head_start_nxt = head_start_r;
    zero_run_nxt   = zero_run_r;
    pos_nxt        = pos_r + hrs_pkg::POS_W'(1);
    n_push         = 2'd0;

    // second word only ever carries a final nonzero sample as its own segment
    res1.amplitude    = in_smp.sample;
    res1.rate_code    = '0;
    res1.start_index  = hrs_pkg::START_W'(pos_r);
    res1.end_index    = pos_end;
    res1.last_segment = 1'b1;

    res0 = res1;

    if (is_zero) begin
      if (head_open_r) begin
        zero_run_nxt = zr_inc;
        if (zr_inc >= hrs_pkg::ABSORB_LIMIT || fin) begin
          // head closes with the absorbed zeros as its rate code
          res0.amplitude    = head_amp_r;
          res0.rate_code    = zr_inc;
          res0.start_index  = hrs_pkg::START_W'(head_start_r);
          res0.end_index    = pos_end;
          res0.last_segment = fin;
          n_push            = 2'd1;
          head_open_nxt     = 1'b0;
          zero_run_nxt      = '0;
        end
      end else begin
        // lone zero
        res0.amplitude    = '0;
        res0.rate_code    = '0;
        res0.start_index  = hrs_pkg::START_W'(pos_r);
        res0.end_index    = pos_end;
        res0.last_segment = fin;
        n_push            = 2'd1;
      end
    end else begin
      head_open_nxt  = !fin;
      head_amp_nxt   = in_smp.sample;
      head_start_nxt = pos_r;
      zero_run_nxt   = '0;
      if (head_open_r) begin
        // new head ends the previous segment just before it
        res0.amplitude    = head_amp_r;
        res0.rate_code    = zero_run_r;
        res0.start_index  = hrs_pkg::START_W'(head_start_r);
        res0.end_index    = hrs_pkg::END_W'(pos_r);
        res0.last_segment = 1'b0;
        n_push            = fin ? 2'd2 : 2'd1;
      end else begin
        n_push = fin ? 2'd1 : 2'd0;
      end
    end

    if (fin) begin
      head_open_nxt = 1'b0;
      zero_run_nxt  = '0;
      pos_nxt       = '0;
    end

    if (!in_acc) begin
      n_push = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_open_r <= 1'b0;
      zero_run_r  <= '0;
      pos_r       <= '0;
    end else if (in_acc) begin
      head_open_r <= head_open_nxt;
      zero_run_r  <= zero_run_nxt;
      pos_r       <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      head_amp_r   <= head_amp_nxt;
      head_start_r <= head_start_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (n_push == 2'd2) begin
      q_r[wr_ptr_r + hrs_pkg::QPTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + hrs_pkg::QPTR_W'(n_push);
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + hrs_pkg::QPTR_W'(1);
      end
      cnt_r <= cnt_r + hrs_pkg::QCNT_W'(n_push) - hrs_pkg::QCNT_W'(out_acc);
    end
  end

  assign out_seg.amplitude    = q_r[rd_ptr_r].amplitude;
  assign out_seg.rate_code    = q_r[rd_ptr_r].rate_code;
  assign out_seg.start_index  = q_r[rd_ptr_r].start_index;
  assign out_seg.end_index    = q_r[rd_ptr_r].end_index;
  assign out_seg.last_segment = q_r[rd_ptr_r].last_segment;

  // Checks
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= hrs_pkg::QCNT_W'(hrs_pkg::QDEPTH))
    else $error("result queue overflow");

  a_run_closed: assert property (@(posedge clk) disable iff (!rst_n)
    !head_open_r |-> zero_run_r == '0)
    else $error("zero run counted without open head");

  a_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
    zero_run_r < hrs_pkg::ABSORB_LIMIT)
    else $error("zero run reached limit while open");

  a_fin_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && fin |=> pos_r == '0 && !head_open_r)
    else $error("stream end did not return to start");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    hrs_pkg::QPTR_W'(wr_ptr_r - rd_ptr_r) == hrs_pkg::QPTR_W'(cnt_r))
    else $error("queue pointers disagree with count");

endmodule

// ===== tb/sv/tb_haptic_rate_segmenter_top.sv =====
`timescale 1ns / 1ps

module tb_haptic_rate_segmenter_top;
  import hrs_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned LONG_HOLD      = 80;

  typedef struct packed {
    logic [AMP_W-1:0] sample;
    logic             final_sample;
  } smp_item_t;

  logic clk;
  logic rst_n;

  hrs_in_if  in_smp ();
  hrs_out_if out_seg ();

  haptic_rate_segmenter_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_smp  (in_smp),
    .out_seg (out_seg)
  );

  // Clock: 20 ns period.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Samples waiting to be offered, and segment words the block still owes us.
  smp_item_t pending_samples[$];
  seg_t      expected_segs[$];

  // Shadow copy of the segmenter state.
  logic               head_open;
  logic [AMP_W-1:0]   head_amp;
  logic [START_W-1:0] head_start;
  logic [RATE_W-1:0]  zero_run;
  logic [END_W-1:0]   position;

  // Idle knobs (percent of cycles), plus a one-shot long output stall.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        hold_req;
  logic        hold_done;
  int unsigned hold_cnt;

  int unsigned error_cnt;
  int unsigned samples_sent;
  int unsigned segs_checked;
  int unsigned streams_closed;
  int unsigned max_start_seen;
  int unsigned stall_cnt;
  smp_item_t   next_item;
  seg_t        exp_seg;

  function automatic void push_seg(input logic [AMP_W-1:0] amp, input logic [RATE_W-1:0] rate,
                                   input logic [START_W-1:0] start,
                                   input logic [END_W-1:0] stop, input logic last);
    seg_t s;
    s.amplitude    = amp;
    s.rate_code    = rate;
    s.start_index  = start;
    s.end_index    = stop;
    s.last_segment = last;
    expected_segs = {expected_segs, s};
  endfunction

  // Per-sample segmenter update; appends the words this sample closes.
  function automatic void predict_segments(input logic [AMP_W-1:0] smp, input logic fin_in);
    logic             fin;
    logic [END_W-1:0] pos;
    fin = fin_in;
    pos = position;
    // Stream too long: the last addressable position always ends it.
    if (32'(pos) + 32'd1 >= MAX_SAMPLES)
      fin = 1'b1;
    if (smp == '0) begin
      if (head_open) begin
        zero_run = zero_run + RATE_W'(1);
        // Fourth absorbed zero closes at the slowest rate.
        if (zero_run >= ABSORB_LIMIT || fin) begin
          push_seg(head_amp, zero_run, head_start, pos + END_W'(1), fin);
          head_open = 1'b0;
          zero_run  = '0;
        end
      end else begin
        // Lone zero: single-sample segment.
        push_seg('0, '0, pos[START_W-1:0], pos + END_W'(1), fin);
      end
    end else begin
      if (head_open)
        push_seg(head_amp, zero_run, head_start, pos, 1'b0);
      head_open  = 1'b1;
      head_amp   = smp;
      head_start = pos[START_W-1:0];
      zero_run   = '0;
      if (fin) begin
        push_seg(smp, '0, pos[START_W-1:0], pos + END_W'(1), 1'b1);
        head_open = 1'b0;
      end
    end
    if (fin) begin
      head_open  = 1'b0;
      head_amp   = '0;
      head_start = '0;
      zero_run   = '0;
      position   = '0;
      streams_closed++;
    end else begin
      position = pos + END_W'(1);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      error_cnt++;
    end
  endfunction

  // Sender: predict on each accepted word, then maybe offer the next one.
  // valid only drops or changes when the current word is gone.
  always @(posedge clk) begin
    if (in_smp.valid && in_smp.ready) begin
      predict_segments(in_smp.sample, in_smp.final_sample);
      samples_sent++;
    end
    if (rst_n && (!in_smp.valid || in_smp.ready)) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_samples.pop_front();
        in_smp.valid        <= 1'b1;
        in_smp.sample       <= next_item.sample;
        in_smp.final_sample <= next_item.final_sample;
      end else begin
        in_smp.valid <= 1'b0;
      end
    end
  end

  // Receiver: check each accepted word against the oldest expectation,
  // then pick ready for the next cycle (random, or a long hold-off).
  always @(posedge clk) begin
    if (out_seg.valid && out_seg.ready) begin
      if (expected_segs.size() == 0) begin
        $display("%0t: unexpected segment, expected none, got amp %0d rate %0d [%0d,%0d) last %0d",
                 $time, out_seg.amplitude, out_seg.rate_code, out_seg.start_index,
                 out_seg.end_index, out_seg.last_segment);
        error_cnt++;
      end else begin
        exp_seg = expected_segs.pop_front();
        check_field("amplitude", exp_seg.amplitude, out_seg.amplitude);
        check_field("rate_code", exp_seg.rate_code, out_seg.rate_code);
        check_field("start_index", exp_seg.start_index, out_seg.start_index);
        check_field("end_index", exp_seg.end_index, out_seg.end_index);
        check_field("last_segment", exp_seg.last_segment, out_seg.last_segment);
        if (out_seg.start_index > max_start_seen)
          max_start_seen = out_seg.start_index;
        segs_checked++;
      end
    end
    if (!rst_n) begin
      out_seg.ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      // Long hold-off: the queue fills and in_smp.ready must drop.
      out_seg.ready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= LONG_HOLD)
        hold_done = 1'b1;
    end else begin
      out_seg.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: cycles with work outstanding but no handshake on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_smp.valid && in_smp.ready) || (out_seg.valid && out_seg.ready))
        stall_cnt = 0;
      else if (pending_samples.size() > 0 || expected_segs.size() > 0 || in_smp.valid)
        stall_cnt++;
      if (stall_cnt >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, stall_cnt);
        $display("tb_haptic_rate_segmenter_top failed");
        $finish;
      end
    end
  end

  task automatic add_sample(input logic [AMP_W-1:0] smp, input logic fin);
    smp_item_t it;
    it.sample       = smp;
    it.final_sample = fin;
    pending_samples = {pending_samples, it};
  endtask

  // One well-formed stream: random content, final on its last sample.
  task automatic add_stream(input int unsigned len, input int unsigned zero_pct);
    int unsigned i;
    logic [AMP_W-1:0] smp;
    for (i = 0; i < len; i++) begin
      smp = ($urandom_range(99) < zero_pct) ? '0 : AMP_W'($urandom_range(255, 1));
      add_sample(smp, i == len - 1);
    end
  endtask

  // Mostly well-formed streams; some noise with final scattered at random.
  task automatic add_random_phase(input int unsigned n_items);
    int unsigned total;
    int unsigned len;
    int unsigned zpct;
    int unsigned i;
    total = 0;
    while (total < n_items) begin
      len = $urandom_range(40, 1);
      case ($urandom_range(3))
        0: zpct = 20;
        1: zpct = 50;
        2: zpct = 80;
        default: zpct = 95;
      endcase
      if ($urandom_range(9) == 0) begin
        for (i = 0; i < len; i++)
          add_sample(AMP_W'($urandom_range(255)), $urandom_range(7) == 0);
        add_sample(AMP_W'($urandom_range(255)), 1'b1);
        len++;
      end else begin
        add_stream(len, zpct);
      end
      total += len;
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_smp.valid)
      @(posedge clk);
  endtask

  task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    in_smp.valid        = 1'b0;
    in_smp.sample       = '0;
    in_smp.final_sample = 1'b0;
    out_seg.ready       = 1'b0;
    head_open      = 1'b0;
    head_amp       = '0;
    head_start     = '0;
    zero_run       = '0;
    position       = '0;
    send_idle_pct  = 13;
    recv_idle_pct  = 81;
    hold_req       = 1'b0;
    hold_done      = 1'b0;
    hold_cnt       = 0;
    error_cnt      = 0;
    samples_sent   = 0;
    segs_checked   = 0;
    streams_closed = 0;
    max_start_seen = 0;
    stall_cnt      = 0;

    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: lone zero, max amplitude head with four absorbed zeros,
    // lone zero after close, head closed by a new head, final head over open head.
    add_sample(8'd0, 1'b0);
    add_sample(8'd255, 1'b0);
    add_sample(8'd0, 1'b0);
    add_sample(8'd0, 1'b0);
    add_sample(8'd0, 1'b0);
    add_sample(8'd0, 1'b0);
    add_sample(8'd0, 1'b0);
    add_sample(8'd1, 1'b0);
    add_sample(8'd0, 1'b0);
    add_sample(8'd0, 1'b0);
    add_sample(8'd170, 1'b0);
    add_sample(8'd85, 1'b1);
    // Final lone zero; open head flushed by a final zero (rate 3).
    add_sample(8'd0, 1'b1);
    add_sample(8'd5, 1'b0);
    add_sample(8'd0, 1'b0);
    add_sample(8'd0, 1'b0);
    add_sample(8'd0, 1'b1);
    // Single final head; fourth absorbed zero that is also final.
    add_sample(8'd9, 1'b1);
    add_sample(8'd128, 1'b0);
    add_sample(8'd0, 1'b0);
    add_sample(8'd0, 1'b0);
    add_sample(8'd0, 1'b0);
    add_sample(8'd0, 1'b1);
    // Head with one zero then final.
    add_sample(8'd127, 1'b0);
    add_sample(8'd0, 1'b1);

    add_random_phase(500);
    wait_drained();

    set_idle(81, 13);
    add_random_phase(500);
    wait_drained();

    // No idling; stall the output long enough to back up the input.
    set_idle(0, 0);
    @(negedge clk);
    hold_req = 1'b1;
    add_random_phase(500);
    wait_drained();

    while (expected_segs.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d samples in %0d streams, %0d segment words checked,",
             samples_sent, streams_closed, segs_checked);
    $display("with sender idling, receiver idling and a long output hold (max start %0d).",
             max_start_seen);
    if (error_cnt == 0) begin
      $display("tb_haptic_rate_segmenter_top passed");
    end else begin
      $display("tb_haptic_rate_segmenter_top failed");
    end
    $finish;
  end

endmodule

// ===== haptic_rate_segmenter_top.f =====
hw/rtl/hrs_pkg.sv
hw/rtl/hrs_in_if.sv
hw/rtl/hrs_out_if.sv
hw/rtl/haptic_rate_segmenter_top.sv
tb/sv/tb_haptic_rate_segmenter_top.sv
